// File: src/swm_pkg.sv
// swm_pkg: shared types, constants and tables of the sliding window mean unit.
// No dependencies; imported by every module under src except swm_divider.
package swm_pkg;

  localparam int SAMPLE_BITS        = 24;
  localparam int FILL_BITS          = 7;
  localparam int CFG_INDEX_BITS     = 2;
  localparam int CFG_DATA_BITS      = 7;
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam int WINDOW_RESET       = 8;
  localparam int QUEUE_DEPTH        = 2;

  // trig / CORDIC fixed point
  localparam int TRIG_BITS     = 18;              // one Q1.14 sine or cosine
  localparam int ZW            = 21;              // Q16 angle accumulator
  localparam int CORDIC_STEPS  = 16;
  localparam int STEP_BITS     = $clog2(CORDIC_STEPS);
  localparam int PI_Q16        = 205887;
  localparam int TWO_PI_Q16    = 411775;
  localparam int HALF_PI_Q16   = 102944;
  localparam int CORDIC_K_Q30  = 652032875;

  // range reduction of |sample*16| by shifted copies of 2pi
  localparam int MOD_TOP       = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
  localparam int MOD_BITS      = (SAMPLE_BITS + 4 > 20) ? SAMPLE_BITS + 4 : 20;
  localparam int MOD_CNT_BITS  = $clog2(MOD_TOP + 2);

  localparam logic signed [ZW-1:0] PI_Z       = ZW'(PI_Q16);
  localparam logic signed [ZW-1:0] NEG_PI_Z   = -ZW'(PI_Q16);
  localparam logic signed [ZW-1:0] TWO_PI_Z   = ZW'(TWO_PI_Q16);
  localparam logic signed [ZW-1:0] HALF_PI_Z  = ZW'(HALF_PI_Q16);
  localparam logic signed [ZW-1:0] NEG_HALF_Z = -ZW'(HALF_PI_Q16);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_MODE  = 2'd1;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic [FILL_BITS-1:0]          fill_count;
    logic                          window_empty;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                          is_clear;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVICT, ST_PREP, ST_MOD, ST_FOLD, ST_ROT,
    ST_STORE, ST_MEAN, ST_VEC, ST_DIV, ST_OUT
  } back_state_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_BITS-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      4'd0:    a = 21'sd51472;
      4'd1:    a = 21'sd30385;
      4'd2:    a = 21'sd16054;
      4'd3:    a = 21'sd8150;
      4'd4:    a = 21'sd4091;
      4'd5:    a = 21'sd2047;
      4'd6:    a = 21'sd1024;
      4'd7:    a = 21'sd512;
      4'd8:    a = 21'sd256;
      4'd9:    a = 21'sd128;
      4'd10:   a = 21'sd64;
      4'd11:   a = 21'sd32;
      4'd12:   a = 21'sd16;
      4'd13:   a = 21'sd8;
      4'd14:   a = 21'sd4;
      default: a = 21'sd2;
    endcase
    return a;
  endfunction

endpackage

// File: src/swm_front.sv
// swm_front: input side of the mean unit; accepts words, classifies them
// and holds them in a short queue for the back end. Depends on swm_pkg.
module swm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  swm_pkg::in_word_t in_data,
  output logic              q_valid,
  output swm_pkg::cmd_t     q_item,
  input  logic              q_pop
);
  import swm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            q_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   count_r;
  logic            push;
  cmd_t            cmd_in;

  assign in_stall = (count_r == NW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    cmd_in.is_clear = (in_data.action == ACT_CLEAR);
    cmd_in.sample   = in_data.sample;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + NW'(push) - NW'(q_pop);
    end
  end

endmodule

// File: src/swm_cordic.sv
// swm_cordic: shared 16-step CORDIC, rotation or vectoring, one step a cycle.
// Depends on swm_pkg for the angle table and command type.
module swm_cordic #(
  parameter int XW = 45
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swm_pkg::cordic_cmd_t         cmd,
  input  logic signed [XW-1:0]         x0,
  input  logic signed [XW-1:0]         y0,
  input  logic signed [swm_pkg::ZW-1:0] z0,
  output logic                         done,
  output logic signed [XW-1:0]         x,
  output logic signed [XW-1:0]         y,
  output logic signed [swm_pkg::ZW-1:0] z
);
  import swm_pkg::*;

  logic                 busy_r, done_r, vec_r;
  logic [STEP_BITS-1:0] step_r;
  logic signed [XW-1:0] x_r, y_r, xs, ys, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt, at;
  logic                 sigma;

  // sigma: rotate so that x -= y>>i, y += x>>i, z -= atan
  always_comb begin
    at    = atan_q16(step_r);
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    sigma = vec_r ? (y_r <= 0) : (z_r >= 0);
    if (sigma) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= cmd.vec_mode;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == STEP_BITS'(CORDIC_STEPS - 1));
      if (cmd.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// File: src/swm_divider.sv
// swm_divider: restoring divider, one quotient bit a cycle, unsigned operands.
// Depends on swm_pkg only by convention (no shared items used beyond style).
module swm_divider #(
  parameter int LW = 30,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [LW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [LW-1:0] quot
);
  localparam int NB = $clog2(LW);

  logic          busy_r, done_r;
  logic [NB-1:0] cnt_r;
  logic [LW-1:0] q_r;
  logic [CW:0]   rem_r, sh;
  logic [CW-1:0] div_r;
  logic          fits;

  always_comb begin
    sh   = {rem_r[CW-1:0], q_r[LW-1]};
    fits = (sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[LW-2:0], fits};
      rem_r <= fits ? sh - {1'b0, div_r} : sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NB'(LW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: src/swm_back.sv
// swm_back: back end of the mean unit; ring of samples, running totals,
// trig and mean sequencer, output register. Uses swm_pkg, swm_cordic, swm_divider.
module swm_back #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             hist_clear,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]  win_size,
  input  logic                             angle_mode,
  input  logic                             q_valid,
  input  swm_pkg::cmd_t                    q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output swm_pkg::out_word_t               out_data
);
  import swm_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int LW = SAMPLE_BITS + AW;
  localparam int TW = 16 + AW;
  localparam int XW = TW + 23;
  localparam int RW = SAMPLE_BITS + 2 * TRIG_BITS;

  localparam logic signed [XW-1:0] K_X   = XW'(CORDIC_K_Q30);
  localparam logic signed [XW-1:0] RND16 = XW'(32768);
  localparam logic signed [ZW-1:0] RND4  = ZW'(8);

  back_state_t state_r, state_nxt;

  logic [AW-1:0]                 write_slot_r;
  logic [CW-1:0]                 held_r;
  logic signed [LW-1:0]          lin_r;
  logic signed [TW-1:0]          sin_r, cos_r;
  logic                          out_valid_r;
  out_word_t                     out_data_r;

  logic signed [SAMPLE_BITS-1:0] smp_r, mean_r;
  logic [MOD_BITS-1:0]           mag_r;
  logic [MOD_CNT_BITS-1:0]       k_r;
  logic                          neg_r, flip_r;
  logic signed [TRIG_BITS-1:0]   sn_r, cs_r;

  logic [RW-1:0]                 ring [WINDOW_MAX];
  logic [RW-1:0]                 rd_data_r;

  // control strobes
  logic        rd_en, ring_we, div_start;
  cordic_cmd_t cor_cmd;

  // helpers
  logic                          evict_need, trig_zero;
  logic [CW:0]                   old_sum;
  logic [AW-1:0]                 old_idx;
  logic signed [SAMPLE_BITS-1:0] ev_smp;
  logic signed [TRIG_BITS-1:0]   ev_sn, ev_cs;
  logic [SAMPLE_BITS-1:0]        smp_abs;
  logic [MOD_BITS-1:0]           mod_sub;
  logic signed [ZW-1:0]          r_s, m0, m1, m2;
  logic                          fold_flip;
  logic signed [XW-1:0]          xs, ys, vx0, vy0, cor_x0, cor_y0;
  logic signed [ZW-1:0]          vz0, cor_z0;
  logic                          cor_done, div_done;
  logic signed [XW-1:0]          cor_x, cor_y, xr_w, yr_w;
  logic signed [ZW-1:0]          cor_z, zr;
  logic signed [TRIG_BITS-1:0]   xr_t, yr_t;
  logic [LW-1:0]                 lin_mag, div_q, q_signed;

  assign evict_need = (held_r >= win_size) && (held_r != '0);
  assign trig_zero  = (sin_r == '0) && (cos_r == '0);

  // oldest slot = write_slot - held, modulo the ring depth
  always_comb begin
    old_sum = (CW+1)'(write_slot_r) + (CW+1)'(WINDOW_MAX) - (CW+1)'(held_r);
    if (old_sum >= (CW+1)'(WINDOW_MAX)) begin
      old_idx = AW'(old_sum - (CW+1)'(WINDOW_MAX));
    end else begin
      old_idx = AW'(old_sum);
    end
  end

  assign ev_smp = rd_data_r[RW-1 -: SAMPLE_BITS];
  assign ev_sn  = rd_data_r[2*TRIG_BITS-1 -: TRIG_BITS];
  assign ev_cs  = rd_data_r[TRIG_BITS-1:0];

  assign smp_abs = smp_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_r) : SAMPLE_BITS'(smp_r);
  assign mod_sub = MOD_BITS'(TWO_PI_Q16) << k_r;

  // reduced angle into [-pi/2, pi/2], flip marks a half-turn fold
  always_comb begin
    r_s = $signed({{(ZW-19){1'b0}}, mag_r[18:0]});
    m0  = neg_r ? -r_s : r_s;
    m1  = m0;
    if (m1 > PI_Z) begin
      m1 = m1 - TWO_PI_Z;
    end
    if (m1 < NEG_PI_Z) begin
      m1 = m1 + TWO_PI_Z;
    end
    fold_flip = 1'b0;
    if (m1 > HALF_PI_Z) begin
      m2        = m1 - PI_Z;
      fold_flip = 1'b1;
    end else if (m1 < NEG_HALF_Z) begin
      m2        = m1 + PI_Z;
      fold_flip = 1'b1;
    end else begin
      m2 = m1;
    end
  end

  // atan2 start vector, left half-plane mirrored with z at +/-pi
  always_comb begin
    xs = XW'(cos_r) <<< 20;
    ys = XW'(sin_r) <<< 20;
    if (xs < 0) begin
      vz0 = (ys >= 0) ? PI_Z : NEG_PI_Z;
      vx0 = -xs;
      vy0 = -ys;
    end else begin
      vz0 = '0;
      vx0 = xs;
      vy0 = ys;
    end
  end

  assign cor_x0 = cor_cmd.vec_mode ? vx0 : K_X;
  assign cor_y0 = cor_cmd.vec_mode ? vy0 : '0;
  assign cor_z0 = cor_cmd.vec_mode ? vz0 : m2;

  assign xr_w = (cor_x + RND16) >>> 16;
  assign yr_w = (cor_y + RND16) >>> 16;
  assign xr_t = xr_w[TRIG_BITS-1:0];
  assign yr_t = yr_w[TRIG_BITS-1:0];
  assign zr   = (cor_z + RND4) >>> 4;

  assign lin_mag  = lin_r[LW-1] ? LW'(-lin_r) : LW'(lin_r);
  assign q_signed = lin_r[LW-1] ? LW'(-div_q) : div_q;

  swm_cordic #(.XW(XW)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cor_cmd),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  swm_divider #(.LW(LW), .CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lin_mag),
    .divisor  (held_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && !out_valid_r) begin
          if (q_item.is_clear) begin
            state_nxt = ST_MEAN;
          end else if (evict_need) begin
            state_nxt = ST_EVICT;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_EVICT: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = angle_mode ? ST_MOD : ST_STORE;
      ST_MOD:   if (k_r == '0) state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = ST_ROT;
      ST_ROT:   if (cor_done) state_nxt = ST_STORE;
      ST_STORE: state_nxt = ST_MEAN;
      ST_MEAN: begin
        if (held_r == '0) begin
          state_nxt = ST_OUT;
        end else if (angle_mode) begin
          state_nxt = trig_zero ? ST_OUT : ST_VEC;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_VEC:   if (cor_done) state_nxt = ST_OUT;
      ST_DIV:   if (div_done) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    ring_we     = 1'b0;
    div_start   = 1'b0;
    cor_cmd     = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop = 1'b1;
          rd_en = !q_item.is_clear && evict_need;
        end
      end
      ST_FOLD:  cor_cmd.start = 1'b1;
      ST_STORE: ring_we = 1'b1;
      ST_MEAN: begin
        if (held_r != '0) begin
          if (angle_mode) begin
            if (!trig_zero) begin
              cor_cmd.start    = 1'b1;
              cor_cmd.vec_mode = 1'b1;
            end
          end else begin
            div_start = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // sample ring: read of the oldest entry, registered
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_slot_r] <= {smp_r, sn_r, cs_r};
    end
    if (rd_en) begin
      rd_data_r <= ring[old_idx];
    end
  end

  // control state and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_slot_r <= '0;
      held_r       <= '0;
      lin_r        <= '0;
      sin_r        <= '0;
      cos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (hist_clear || (q_pop && q_item.is_clear)) begin
        write_slot_r <= '0;
        held_r       <= '0;
        lin_r        <= '0;
        sin_r        <= '0;
        cos_r        <= '0;
      end
      case (state_r)
        ST_EVICT: begin
          lin_r  <= lin_r - LW'(ev_smp);
          sin_r  <= sin_r - TW'(ev_sn);
          cos_r  <= cos_r - TW'(ev_cs);
          held_r <= held_r - 1'b1;
        end
        ST_STORE: begin
          lin_r  <= lin_r + LW'(smp_r);
          sin_r  <= sin_r + TW'(sn_r);
          cos_r  <= cos_r + TW'(cs_r);
          held_r <= held_r + 1'b1;
          write_slot_r <= (write_slot_r == AW'(WINDOW_MAX - 1)) ? '0 : write_slot_r + 1'b1;
        end
        ST_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      smp_r <= q_item.sample;
    end
    case (state_r)
      ST_PREP: begin
        mag_r <= MOD_BITS'({smp_abs, 4'b0000});
        neg_r <= smp_r[SAMPLE_BITS-1];
        k_r   <= MOD_CNT_BITS'(MOD_TOP);
        sn_r  <= '0;
        cs_r  <= '0;
      end
      ST_MOD: begin
        if (mag_r >= mod_sub) begin
          mag_r <= mag_r - mod_sub;
        end
        k_r <= k_r - 1'b1;
      end
      ST_FOLD: flip_r <= fold_flip;
      ST_ROT: begin
        if (cor_done) begin
          cs_r <= flip_r ? -xr_t : xr_t;
          sn_r <= flip_r ? -yr_t : yr_t;
        end
      end
      ST_MEAN: mean_r <= '0;
      ST_VEC:  if (cor_done) mean_r <= SAMPLE_BITS'(zr);
      ST_DIV:  if (div_done) mean_r <= q_signed[SAMPLE_BITS-1:0];
      ST_OUT: begin
        out_data_r.mean_value   <= mean_r;
        out_data_r.fill_count   <= FILL_BITS'(held_r);
        out_data_r.window_empty <= (held_r == '0);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_held_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= win_size)
    else $error("fill count above window size");

  a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    int'(write_slot_r) < WINDOW_MAX)
    else $error("write slot outside ring");

  a_pop_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid_r)
    else $error("item taken while result still pending");

  a_store_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE && !hist_clear) |=> held_r != '0)
    else $error("store left window empty");

endmodule

// File: src/sliding_window_mean_unit.sv
// sliding_window_mean_unit: top level of the sliding window mean block.
// Holds the config registers; uses swm_pkg, swm_front and swm_back.
//
// Use:
//  - in_valid/in_stall/in_data carry one word per item: action 0 appends a
//    Q11.12 sample, action 1 empties the window. A word moves on an edge with
//    valid high and stall low. The front queue holds two words, so the
//    sender keeps going while the back end works or a result waits.
//  - out_valid/out_stall/out_data give one result word per item: mean,
//    fill count and empty flag. A stalled result sits in the output register;
//    the back end starts no new item until it is taken, and the queue fills.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write window_size (index 0,
//    clamped to 1..WINDOW_MAX) or angle_mode (index 1). Either write empties
//    the window; other indexes are ignored. Write only while idle.
// From queue pop to result valid: a clear passes only through the mean and
// output states. An append in linear mode waits on the bit-serial divider (one
// quotient bit per cycle over the 30-bit running sum). In angle mode it runs
// range reduction (9 steps), a 16-step sin/cos CORDIC and a 16-step atan2
// CORDIC on one shared unit. One item at a time in the back end.
// Reset: window empty, window_size 8, linear mode; no ring clearing pass.
module sliding_window_mean_unit #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  swm_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output swm_pkg::out_word_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [swm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import swm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int WIN_INIT = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  logic [CW-1:0] win_size_r, win_size_nxt;
  logic          angle_r, angle_nxt;
  logic          hist_clear;

  logic          q_valid, q_pop;
  cmd_t          q_item;

  // config is taken on any cycle; the contract keeps writes to idle time
  assign cfg_ready = 1'b1;

  always_comb begin
    int v;
    v            = int'(cfg_data);
    win_size_nxt = win_size_r;
    angle_nxt    = angle_r;
    hist_clear   = 1'b0;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: begin
          if (v < 1) v = 1;
          if (v > WINDOW_MAX) v = WINDOW_MAX;
          win_size_nxt = CW'(v);
          hist_clear   = 1'b1;
        end
        CFG_ANGLE_MODE: begin
          angle_nxt  = cfg_data[0];
          hist_clear = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= CW'(WIN_INIT);
      angle_r    <= 1'b0;
    end else begin
      win_size_r <= win_size_nxt;
      angle_r    <= angle_nxt;
    end
  end

  // front: accept and queue
  swm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: ring, totals, trig, mean, output register
  swm_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hist_clear (hist_clear),
    .win_size   (win_size_r),
    .angle_mode (angle_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: bench/sliding_window_mean_unit_test.sv
// Self-checking bench for sliding_window_mean_unit: linear and angle means.
// Depends on swm_pkg and the unit; a small scoreboard predicts every result word.
module sliding_window_mean_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;  // unmapped indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;
  localparam int RING_DEPTH   = 64;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_CYCLES = 80;  // room for the longest append, in angle mode

  // Mirrors the window: ring, running totals, config. Holds expected words.
  class mean_scoreboard;
    longint    ring[RING_DEPTH];
    int        slot, held, win_len;
    bit        angle_on;
    longint    lin_sum, sin_sum, cos_sum;
    out_word_t pending[$];
    int        errors;
    longint    atan_tab[16] = '{51472, 30385, 16054, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2};

    function new();
      win_len = WINDOW_RESET;
      angle_on = 0;
      errors = 0;
      empty_out();
    endfunction

    function void empty_out();
      slot = 0; held = 0; lin_sum = 0; sin_sum = 0; cos_sum = 0;
    endfunction

    function void configure(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == CFG_WINDOW_SIZE) begin
        win_len = (val == 0) ? 1 : (val > RING_DEPTH) ? RING_DEPTH : int'(val);
        empty_out();
      end else if (idx == CFG_ANGLE_MODE) begin
        angle_on = val[0];
        empty_out();
      end
    endfunction

    // sin/cos of a Q11.12 angle, Q1.14, via 16-step rotation
    function void sin_cos(longint a, output longint sn, output longint cs);
      longint m, x, y, nx;
      bit flip;
      m = (a * 16) % TWO_PI_Q16;
      x = CORDIC_K_Q30; y = 0; flip = 0;
      if (m > PI_Q16) m -= TWO_PI_Q16;
      if (m < -PI_Q16) m += TWO_PI_Q16;
      if (m > HALF_PI_Q16) begin
        m -= PI_Q16; flip = 1;
      end else if (m < -HALF_PI_Q16) begin
        m += PI_Q16; flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (m >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); m -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); m += atan_tab[i];
        end
        x = nx;
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function longint heading(longint ys, longint xc);
      longint x, y, z, nx;
      if (ys == 0 && xc == 0) return 0;
      x = xc * (64'sd1 << 20); y = ys * (64'sd1 << 20); z = 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q16 : -PI_Q16;
        x = -x; y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end else begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end
        x = nx;
      end
      return (z + 8) >>> 4;
    endfunction

    function void note_input(in_word_t w);
      longint s, sn, cs, old, avg;
      out_word_t r;
      avg = 0;
      if (w.action == ACT_CLEAR) empty_out();
      else begin
        s = longint'($signed(w.sample));
        if (held >= win_len && held > 0) begin
          old = ring[(slot + RING_DEPTH - (held % RING_DEPTH)) % RING_DEPTH];
          sin_cos(old, sn, cs);
          lin_sum -= old; sin_sum -= sn; cos_sum -= cs;
          held--;
        end
        ring[slot] = s;
        sin_cos(s, sn, cs);
        lin_sum += s; sin_sum += sn; cos_sum += cs;
        held++;
        slot = (slot + 1) % RING_DEPTH;
      end
      if (held > 0) avg = angle_on ? heading(sin_sum, cos_sum) : lin_sum / held;
      r.mean_value   = avg[SAMPLE_BITS-1:0];
      r.fill_count   = held[FILL_BITS-1:0];
      r.window_empty = (held == 0);
      pending = {pending, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: mean %0d fill %0d", got.mean_value, got.fill_count);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.mean_value !== want.mean_value) begin
        $error("mean_value: expected %0d, got %0d", want.mean_value, got.mean_value);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        errors++;
      end
      if (got.window_empty !== want.window_empty) begin
        $error("window_empty: expected %0d, got %0d", want.window_empty, got.window_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t  in_data;
  out_word_t out_data;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mean_scoreboard sb = new();
  bit quiet;        // no idling on either side
  int cycles;

  sliding_window_mean_unit dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // accepted words, both directions, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls: random free runs, then random bursts of stall unless quiet
  initial begin
    out_stall = 0;
    forever begin
      repeat ($urandom_range(40)) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1;
        repeat ($urandom_range(18, 1)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // one input word; idling for the given gap comes first
  task automatic send_word(logic act, logic [SAMPLE_BITS-1:0] smp, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{action: act, sample: smp};
    in_valid <= 1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic random_gap(output int gap);
    gap = (!quiet && $urandom_range(5) == 0) ? $urandom_range(18, 1) : 0;
  endtask

  // sender holds off until every expected word is back, then lets it settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // mostly appends with full-range or small values; some clears
  task automatic random_run(int count);
    int gap;
    logic [SAMPLE_BITS-1:0] smp;
    for (int n = 0; n < count; n++) begin
      random_gap(gap);
      case ($urandom_range(9))
        0:       smp = $urandom;
        1, 2:    smp = $urandom_range(25736) - 12868;   // about -pi..pi
        default: smp = $urandom_range(4096) - 2048;
      endcase
      send_word(($urandom_range(24) == 0) ? ACT_CLEAR : ACT_APPEND, smp, gap);
    end
  endtask

  initial begin
    int gap;
    logic [CFG_DATA_BITS-1:0] sizes[10] = '{1, 64, 8, 1, 64, 0, 127, 100, 3, 17};
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_index = '0;
    cfg_data = '0; quiet = 0; cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, clear, eviction in the reset window of 8
    send_word(ACT_APPEND, 24'h7FFFFF, 0);
    send_word(ACT_APPEND, 24'h800000, 0);
    send_word(ACT_APPEND, 24'hFFFFFF, 2);
    send_word(ACT_CLEAR, 24'h000000, 0);
    send_word(ACT_CLEAR, 24'hFFFFFF, 0);   // clear of an empty window
    for (int k = 0; k < 10; k++) send_word(ACT_APPEND, 24'h7FFFFF - k, k % 3);
    drain();

    // angle mode: zero, +/-pi, opposite angles, huge angles
    write_reg(CFG_ANGLE_MODE, 7'd1);
    send_word(ACT_APPEND, 24'd0, 0);
    send_word(ACT_APPEND, 24'd12868, 0);
    send_word(ACT_APPEND, -24'sd12868, 0);
    send_word(ACT_APPEND, 24'h7FFFFF, 0);
    send_word(ACT_APPEND, 24'h800000, 0);
    send_word(ACT_CLEAR, 24'd0, 0);
    send_word(ACT_APPEND, 24'd6434, 0);
    send_word(ACT_APPEND, -24'sd6434, 0);
    drain();

    // unmapped indexes leave the window alone
    write_reg(CFG_SPARE_A, 7'h7F);
    write_reg(CFG_SPARE_B, 7'h00);
    send_word(ACT_APPEND, 24'd100, 0);
    drain();

    foreach (sizes[p]) begin
      write_reg(CFG_WINDOW_SIZE, sizes[p]);
      write_reg(CFG_ANGLE_MODE, {6'($urandom), 1'(p % 2)});
      if (p == 9) quiet = 1;
      random_run(200);
      drain();
    end

    if (sb.pending.size() != 0) begin
      $error("%0d expected result words never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
